// ===== design/stq_pkg.sv =====
// Shared types, codes and helpers for the sorted timer queue.
`default_nettype none
package stq_pkg;

  localparam int unsigned ID_COUNT = 16;
  localparam int unsigned ID_W     = 4;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned ENTRY_W  = TIME_W + ID_W;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_EXPIRE = 2'd2,
    REQ_UNUSED = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    KIND_EXPIRED  = 2'd0,
    KIND_REARM    = 2'd1,
    KIND_SHUTDOWN = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   id;
  } entry_t;

  // Time left until expiry, never below one.
  function automatic logic [TIME_W-1:0] rearm_delta(input logic [TIME_W-1:0] expiry,
                                                    input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] res;
    res = (expiry > now) ? (expiry - now) : TIME_W'(1);
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== design/stq_ram.sv =====
// Generic single-port-write, registered-read RAM.
`default_nettype none
module stq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data between reads
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/sorted_timer_queue_core.sv =====
// Top level of the sorted timer queue: sequencer over two ping-pong queue banks.
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+-------------------------------------
//  request   | in        | start_i, busy_o               | req_type, timer_id, delay_ns, ...
//  result    | out       | result_valid_o (one cycle)    | kind, expired_id, rearm_delta, last
//  config    | in        | cfg_we_i                      | cfg_wdata_i (device_ready)
//
// Each request beat that is not ignored walks the whole queue once: every stored
// entry is read from the active bank (a read state, then a data state, and one
// more data state where a new timer is slotted in) and the surviving entries are
// written, in order, to the other bank, which then becomes active. An ignored
// request goes straight to the done state.
// Reset clears the queue count, the queued flags and device_ready; the banks are
// not cleared, since only entries below the count are ever read.
// The receiver cannot stall: each result beat stands for one cycle only, and
// expired beats go out while the walk is still running.
`default_nettype none
module sorted_timer_queue_core #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [3:0]  timer_id_i,
  input  wire logic [63:0] delay_ns_i,
  input  wire logic        has_handler_i,
  input  wire logic [63:0] now_ns_i,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_wdata_i,
  // result channel
  output logic             result_valid_o,
  output logic [1:0]       kind_o,
  output logic [3:0]       expired_id_o,
  output logic [63:0]      rearm_delta_o,
  output logic             last_o
);

  localparam int unsigned AW = $clog2(NUM_TIMERS);
  localparam int unsigned CW = $clog2(NUM_TIMERS + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_DATA = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e                               state_q, state_d;
  logic                                 bank_q, bank_d;
  logic [CW-1:0]                        cnt_q, cnt_d;
  logic [CW-1:0]                        rd_q, rd_d;
  logic [CW-1:0]                        wr_q, wr_d;
  logic                                 ins_q, ins_d;     // new timer already written
  logic                                 pos0_q, pos0_d;   // new timer landed at the head
  logic                                 pop_q, pop_d;     // still in the due prefix
  logic [stq_pkg::TIME_W-1:0]           head_q, head_d;
  logic [1:0]                           req_q, req_d;
  logic [stq_pkg::ID_W-1:0]             id_q, id_d;
  logic [stq_pkg::TIME_W-1:0]           exp_q, exp_d;
  logic [stq_pkg::TIME_W-1:0]           now_q, now_d;
  logic [stq_pkg::ID_COUNT-1:0]         queued_q, queued_d;
  logic                                 ready_q;

  logic                                 vld_d;
  logic [1:0]                           kind_d;
  logic [3:0]                           eid_d;
  logic [63:0]                          delta_d;
  logic                                 last_d;

  logic                                 ram_we, ram_re;
  logic [AW-1:0]                        ram_waddr, ram_raddr;
  stq_pkg::entry_t                      ram_wdata, ent;
  logic [stq_pkg::ENTRY_W-1:0]          rdata0, rdata1;

  logic                                 accept;
  logic                                 add_ok;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;
  assign ent    = stq_pkg::entry_t'(bank_q ? rdata1 : rdata0);
  assign add_ok = ready_q && (delay_ns_i != '0) && has_handler_i &&
                  (queued_q[timer_id_i] || (cnt_q < CW'(NUM_TIMERS)));

  // both banks see the same read address; writes go to the inactive bank
  stq_ram #(.WIDTH(stq_pkg::ENTRY_W), .DEPTH(NUM_TIMERS)) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (ram_we && bank_q),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata0)
  );

  stq_ram #(.WIDTH(stq_pkg::ENTRY_W), .DEPTH(NUM_TIMERS)) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (ram_we && !bank_q),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(rdata1)
  );

  always_comb begin
    state_d   = state_q;
    bank_d    = bank_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    wr_d      = wr_q;
    ins_d     = ins_q;
    pos0_d    = pos0_q;
    pop_d     = pop_q;
    head_d    = head_q;
    req_d     = req_q;
    id_d      = id_q;
    exp_d     = exp_q;
    now_d     = now_q;
    queued_d  = queued_q;
    vld_d     = 1'b0;
    kind_d    = stq_pkg::KIND_NONE;
    eid_d     = '0;
    delta_d   = '0;
    last_d    = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = wr_q[AW-1:0];
    ram_raddr = rd_q[AW-1:0];
    ram_wdata = ent;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d  = req_type_i;
          id_d   = timer_id_i;
          now_d  = now_ns_i;
          exp_d  = now_ns_i + delay_ns_i;
          rd_d   = '0;
          wr_d   = '0;
          ins_d  = 1'b0;
          pos0_d = 1'b0;
          pop_d  = 1'b1;
          state_d = S_DONE;
          case (req_type_i)
            stq_pkg::REQ_ADD: begin
              if (add_ok) begin
                queued_d[timer_id_i] = 1'b1;
                state_d = (cnt_q != '0) ? S_READ : S_DATA;
              end else begin
                // ignored add answers only with a final KIND_NONE beat
                req_d = stq_pkg::REQ_UNUSED;
              end
            end
            stq_pkg::REQ_CANCEL: begin
              queued_d[timer_id_i] = 1'b0;
              if (cnt_q != '0) begin
                state_d = S_READ;
              end
            end
            stq_pkg::REQ_EXPIRE: begin
              state_d = (cnt_q != '0) ? S_READ : S_DATA;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_DATA;
      end

      S_DATA: begin
        if (rd_q == cnt_q) begin
          // walk finished: slot the new timer at the tail if still pending
          if (req_q == stq_pkg::REQ_ADD && !ins_q) begin
            ram_we    = 1'b1;
            ram_wdata = '{expiry: exp_q, id: id_q};
            pos0_d    = (wr_q == '0);
            wr_d      = wr_q + CW'(1);
          end
          state_d = S_DONE;
        end else if (req_q == stq_pkg::REQ_ADD && !ins_q && ent.expiry > exp_q) begin
          // insert ahead of the held entry, revisit it next cycle
          ram_we    = 1'b1;
          ram_wdata = '{expiry: exp_q, id: id_q};
          pos0_d    = (wr_q == '0);
          ins_d     = 1'b1;
          wr_d      = wr_q + CW'(1);
        end else begin
          rd_d = rd_q + CW'(1);
          if (req_q == stq_pkg::REQ_EXPIRE && pop_q && ent.expiry <= now_q) begin
            vld_d  = 1'b1;
            kind_d = stq_pkg::KIND_EXPIRED;
            eid_d  = ent.id;
            queued_d[ent.id] = 1'b0;
          end else if (req_q != stq_pkg::REQ_EXPIRE && ent.id == id_q) begin
            // drop the old copy of this timer
          end else begin
            pop_d  = 1'b0;
            ram_we = 1'b1;
            if (wr_q == '0) begin
              head_d = ent.expiry;
            end
            wr_d = wr_q + CW'(1);
          end
          state_d = (rd_q + CW'(1) == cnt_q) ? S_DATA : S_READ;
        end
      end

      S_DONE: begin
        vld_d   = 1'b1;
        last_d  = 1'b1;
        state_d = S_IDLE;
        if (req_q == stq_pkg::REQ_ADD || req_q == stq_pkg::REQ_CANCEL ||
            req_q == stq_pkg::REQ_EXPIRE) begin
          cnt_d  = wr_q;
          bank_d = !bank_q;
        end
        case (req_q)
          stq_pkg::REQ_ADD: begin
            if (pos0_q) begin
              kind_d  = stq_pkg::KIND_REARM;
              delta_d = stq_pkg::rearm_delta(exp_q, now_q);
            end
          end
          stq_pkg::REQ_EXPIRE: begin
            if (!ready_q) begin
              kind_d = stq_pkg::KIND_NONE;
            end else if (wr_q != '0) begin
              kind_d  = stq_pkg::KIND_REARM;
              delta_d = stq_pkg::rearm_delta(head_q, now_q);
            end else begin
              kind_d = stq_pkg::KIND_SHUTDOWN;
            end
          end
          default: begin
            kind_d = stq_pkg::KIND_NONE;
          end
        endcase
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      bank_q         <= 1'b0;
      cnt_q          <= '0;
      queued_q       <= '0;
      ready_q        <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      bank_q         <= bank_d;
      cnt_q          <= cnt_d;
      queued_q       <= queued_d;
      result_valid_o <= vld_d;
      if (cfg_we_i) begin
        ready_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q          <= rd_d;
    wr_q          <= wr_d;
    ins_q         <= ins_d;
    pos0_q        <= pos0_d;
    pop_q         <= pop_d;
    head_q        <= head_d;
    req_q         <= req_d;
    id_q          <= id_d;
    exp_q         <= exp_d;
    now_q         <= now_d;
    kind_o        <= kind_d;
    expired_id_o  <= eid_d;
    rearm_delta_o <= delta_d;
    last_o        <= last_d;
  end

`ifndef NO_ASSERTIONS
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy_o)
    else $error("final result beat while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted request did not raise busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(NUM_TIMERS))
    else $error("queue count beyond capacity");

  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o |-> ($countones(queued_q) == int'(cnt_q)))
    else $error("queued flags disagree with queue count");
`endif

endmodule
`default_nettype wire
